// ----- hw/rtl/rrt_pkg.sv -----
package rrt_pkg;

  localparam int MaxNodesDef  = 128;
  localparam int CoordBitsDef = 7;
  localparam int CfgIdxBits   = 2;
  localparam int OutBits      = 7;

  localparam logic [CfgIdxBits-1:0] CfgRootCol = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgRootRow = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgStep    = 2'd2;

  localparam int RootReset = 49;
  localparam int StepReset = 10;

endpackage

// ----- hw/rtl/rrt_nearest_and_steer_top.sv -----
// A sample passes through the node scan (a read and a compare state per stored node),
// then the integer square root and, for a steered sample, two serial divides (column,
// then row) before the result is valid.
// Throughput: one sample at a time in the back; a 2-entry queue in front.
// Reset (async, active low): tree holds the root only, registers take
// root 49,49 and step 10; node store contents are undefined.
module rrt_nearest_and_steer_top import rrt_pkg::*; #(
  parameter int MAX_NODES  = MaxNodesDef,
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [COORD_BITS-1:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [COORD_BITS-1:0] sample_col_i,
  input  logic [COORD_BITS-1:0] sample_row_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [OutBits-1:0] new_col_o,
  output logic [OutBits-1:0] new_row_o,
  output logic [OutBits-1:0] new_index_o,
  output logic [OutBits-1:0] parent_index_o,
  output logic stored_o
);
  logic [COORD_BITS-1:0] root_col_q, root_row_q, step_q;
  logic qv, qr;
  logic [2*COORD_BITS-1:0] qd;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_col_q <= COORD_BITS'(RootReset);
      root_row_q <= COORD_BITS'(RootReset);
      step_q <= COORD_BITS'(StepReset);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgRootCol: root_col_q <= cfg_data_i;
        CfgRootRow: root_row_q <= cfg_data_i;
        CfgStep:    step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rrt_queue #(.W(2*COORD_BITS)) u_q (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .in_data_i({sample_col_i, sample_row_i}),
    .out_valid_o(qv), .out_ready_i(qr), .out_data_o(qd)
  );

  rrt_back #(.MAX_NODES(MAX_NODES), .COORD_BITS(COORD_BITS)) u_back (
    .clk_i, .rst_ni, .root_col_i(root_col_q), .root_row_i(root_row_q),
    .step_i(step_q), .in_valid_i(qv), .in_ready_o(qr), .in_data_i(qd),
    .out_valid_o, .out_ready_i, .new_col_o, .new_row_o, .new_index_o,
    .parent_index_o, .stored_o
  );
endmodule

// ----- hw/rtl/rrt_queue.sv -----
// Two-entry queue of samples between the front and the back.
module rrt_queue import rrt_pkg::*; #(
  parameter int W = 14
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [W-1:0] in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [W-1:0] out_data_o
);
  logic [W-1:0] mem_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;
  logic         push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- hw/rtl/rrt_back.sv -----
// Scan, integer square root, steering divide, store write, result register.
module rrt_back import rrt_pkg::*; #(
  parameter int MAX_NODES  = MaxNodesDef,
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [COORD_BITS-1:0] root_col_i,
  input  logic [COORD_BITS-1:0] root_row_i,
  input  logic [COORD_BITS-1:0] step_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2*COORD_BITS-1:0] in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OutBits-1:0]    new_col_o,
  output logic [OutBits-1:0]    new_row_o,
  output logic [OutBits-1:0]    new_index_o,
  output logic [OutBits-1:0]    parent_index_o,
  output logic                  stored_o
);
  localparam int CB = COORD_BITS;
  localparam int IB = $clog2(MAX_NODES);
  localparam int NB = $clog2(MAX_NODES + 1);
  localparam int SB = 2*CB + 1;            // squared distance
  localparam int PB = 2*CB + 1;            // |step*diff|
  localparam int SQI = (SB + 1) / 2;       // sqrt iterations
  localparam int KB = $clog2(PB + 2);      // divide step counter

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_RD = 7'b0000010, S_CMP = 7'b0000100,
    S_SQRT = 7'b0001000, S_DIVC = 7'b0010000, S_DIVR = 7'b0100000,
    S_OUT = 7'b1000000
  } state_e;
  state_e st_q;

  logic [CB-1:0] mcol [MAX_NODES];
  logic [CB-1:0] mrow [MAX_NODES];
  logic [CB-1:0] rc_q, rr_q;
  logic          rz_q;

  logic [NB-1:0] cnt_q;
  logic [IB-1:0] idx_q, rdi_q, best_q;
  logic [CB-1:0] sc_q, sr_q, nc_q, nr_q;
  logic [SB-1:0] best_sq_q, v_q;
  logic [SB:0]   res_q, bit_q;
  logic          last_q;
  logic [PB-1:0] num_q, quo_q, rem_q;
  logic [KB-1:0] k_q;
  logic          neg_q;
  logic [CB-1:0] oc_q, or_q;

  // registered store read
  always_ff @(posedge clk_i) begin
    rc_q <= mcol[rdi_q];
    rr_q <= mrow[rdi_q];
    rz_q <= (rdi_q == '0);
  end

  // squared distance of the node under compare
  logic [CB-1:0] pc, pr;
  logic signed [CB:0] dcs, drs;
  logic signed [2*CB+1:0] dcsq, drsq;
  logic [SB-1:0] q;
  assign pc   = rz_q ? root_col_i : rc_q;
  assign pr   = rz_q ? root_row_i : rr_q;
  assign dcs  = $signed({1'b0, sc_q}) - $signed({1'b0, pc});
  assign drs  = $signed({1'b0, sr_q}) - $signed({1'b0, pr});
  assign dcsq = dcs * dcs;
  assign drsq = drs * drs;
  assign q    = dcsq[SB-1:0] + drsq[SB-1:0];

  logic full;
  assign full = (cnt_q == NB'(MAX_NODES));
  assign in_ready_o = (st_q == S_IDLE);

  // sqrt trial and steering helpers
  logic [SB:0] trial;
  assign trial = res_q + bit_q;
  logic steer;
  assign steer = res_q > {{(SB+1-CB){1'b0}}, step_i};

  logic signed [CB:0] dsel, ndsel;
  logic [CB-1:0] absd;
  logic [2*CB-1:0] prod;
  logic [PB-1:0] absd_prod;
  assign dsel = (st_q == S_DIVR) ? $signed({1'b0, sr_q}) - $signed({1'b0, nr_q})
                                 : $signed({1'b0, sc_q}) - $signed({1'b0, nc_q});
  assign ndsel = -dsel;
  assign absd = dsel[CB] ? ndsel[CB-1:0] : dsel[CB-1:0];
  assign prod = absd * step_i;
  assign absd_prod = {1'b0, prod};

  // restoring divide step, divisor is the square root
  logic [PB:0] rsh, rdiff;
  assign rsh   = {rem_q, num_q[PB-1]};
  assign rdiff = rsh - res_q;

  // floor for negative offsets rounds the magnitude up
  logic [PB-1:0] qf;
  assign qf = quo_q + {{(PB-1){1'b0}}, neg_q && (rem_q != '0)};

  logic out_load;
  assign out_load = (st_q == S_OUT) && (!out_valid_o || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      cnt_q <= NB'(1);
      out_valid_o <= 1'b0;
      idx_q <= '0; rdi_q <= '0; best_q <= '0;
      last_q <= 1'b0;
      sc_q <= '0; sr_q <= '0; nc_q <= '0; nr_q <= '0;
      best_sq_q <= '0; v_q <= '0; res_q <= '0; bit_q <= '0;
      num_q <= '0; quo_q <= '0; rem_q <= '0; k_q <= '0; neg_q <= 1'b0;
      oc_q <= '0; or_q <= '0;
      new_col_o <= '0; new_row_o <= '0; new_index_o <= '0;
      parent_index_o <= '0; stored_o <= 1'b0;
    end else begin
      // result register handshake
      if (out_load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
      case (st_q)
        S_IDLE: if (in_valid_i) begin
          {sc_q, sr_q} <= in_data_i;
          rdi_q <= '0; idx_q <= '0; best_q <= '0;
          best_sq_q <= '1;
          last_q <= (cnt_q == NB'(1));
          st_q <= S_RD;
        end
        S_RD: begin
          // read of rdi_q is in flight; advance address
          idx_q <= rdi_q;
          if (!last_q) rdi_q <= rdi_q + 1'b1;
          last_q <= (NB'(rdi_q) + NB'(2) >= cnt_q);
          st_q <= S_CMP;
        end
        S_CMP: begin
          if (q < best_sq_q) begin
            best_sq_q <= q; best_q <= idx_q;
            nc_q <= pc; nr_q <= pr;
          end
          if (NB'(idx_q) + NB'(1) >= cnt_q) begin
            st_q <= S_SQRT;
            res_q <= '0;
            bit_q <= (SB+1)'(1) << (2*(SQI-1));
            v_q <= (q < best_sq_q) ? q : best_sq_q;
          end else begin
            st_q <= S_RD;
          end
        end
        S_SQRT: begin
          if ({1'b0, v_q} >= trial) begin
            v_q <= v_q - trial[SB-1:0];
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q[0]) begin
            st_q <= S_DIVC;
            k_q <= '0;
          end
        end
        S_DIVC, S_DIVR: begin
          if (!steer) begin
            oc_q <= sc_q; or_q <= sr_q;
            st_q <= S_OUT;
          end else if (k_q == '0) begin
            num_q <= absd_prod; neg_q <= dsel[CB];
            rem_q <= '0; quo_q <= '0;
            k_q <= KB'(1);
          end else if (k_q <= KB'(PB)) begin
            num_q <= {num_q[PB-2:0], 1'b0};
            k_q <= k_q + 1'b1;
            if (rsh >= res_q) begin
              rem_q <= rdiff[PB-1:0];
              quo_q <= {quo_q[PB-2:0], 1'b1};
            end else begin
              rem_q <= rsh[PB-1:0];
              quo_q <= {quo_q[PB-2:0], 1'b0};
            end
          end else begin
            if (st_q == S_DIVC) begin
              oc_q <= neg_q ? nc_q - qf[CB-1:0] : nc_q + qf[CB-1:0];
              st_q <= S_DIVR;
            end else begin
              or_q <= neg_q ? nr_q - qf[CB-1:0] : nr_q + qf[CB-1:0];
              st_q <= S_OUT;
            end
            k_q <= '0;
          end
        end
        S_OUT: if (out_load) begin
          new_col_o <= OutBits'(oc_q);
          new_row_o <= OutBits'(or_q);
          parent_index_o <= OutBits'(best_q);
          stored_o <= !full;
          new_index_o <= full ? '0 : OutBits'(cnt_q);
          if (!full) cnt_q <= cnt_q + 1'b1;
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // store write
  always_ff @(posedge clk_i) begin
    if (out_load && !full) begin
      mcol[IB'(cnt_q)] <= oc_q;
      mrow[IB'(cnt_q)] <= or_q;
    end
  end
endmodule

// ----- hw/rtl/rrt_checker.sv -----
module rrt_checker import rrt_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic stored_o,
  input logic [OutBits-1:0] new_index_o,
  input logic [OutBits-1:0] parent_index_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(new_index_o))
    else $error("result dropped");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !stored_o |-> new_index_o == '0)
    else $error("index on full");
  a_par: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stored_o && new_index_o != '0 |-> parent_index_o < new_index_o)
    else $error("parent not older");
endmodule

bind rrt_nearest_and_steer_top rrt_checker u_chk (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .stored_o,
  .new_index_o, .parent_index_o
);
